// ===== design/snfrl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snfrl_pkg
// Shared constants and types of the SYN flood rate limiter.
// ----------------------------------------------------------------------------
package snfrl_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int WAYS_DEF          = 4;

    localparam logic [15:0] MIN_FRAME      = 16'd54;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;

    localparam logic [15:0] RATE_LIMIT_RST = 16'd100;
    localparam logic [39:0] WINDOW_NS_RST  = 40'd1000000000;

    typedef enum logic [0:0] {
        CFG_RATE_LIMIT = 1'b0,
        CFG_WINDOW_NS  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        OUT_UNTRACKED = 3'd0,
        OUT_NEW       = 3'd1,
        OUT_RESTART   = 3'd2,
        OUT_COUNTED   = 3'd3,
        OUT_OVER      = 3'd4
    } outcome_t;

endpackage

// ===== design/snfrl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snfrl interfaces
// Packet, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface snfrl_pkt_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic        syn_flag;
    logic        ack_flag;
    logic [31:0] source_address;
    logic [63:0] now_ns;

    modport source (output valid, frame_length, ether_type, ip_protocol, syn_flag,
                    ack_flag, source_address, now_ns, input ready);
    modport sink   (input valid, frame_length, ether_type, ip_protocol, syn_flag,
                    ack_flag, source_address, now_ns, output ready);
endinterface

interface snfrl_res_if;
    logic       valid;
    logic       ready;
    logic       drop;
    logic [2:0] outcome;

    modport source (output valid, drop, outcome, input ready);
    modport sink   (input valid, drop, outcome, output ready);
endinterface

interface snfrl_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [39:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/syn_flood_rate_limiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// syn_flood_rate_limiter
// Per-source fixed-window SYN rate limiter over a set-associative table.
// ----------------------------------------------------------------------------
// Usage:
//   pkt carries one parsed packet header per transfer; res returns one
//   drop/outcome result per packet, in packet order. cfg writes rate_limit
//   (index 0) or window_ns (index 1); write only while no packet is pending.
// Processing:
//   the classifier holds one packet at a time and, when the set count is
//   not a power of two, finds the set by reciprocal multiply, quotient then
//   remainder. The table engine returns an untracked packet's result on
//   the queue pop; a tracked one passes RAM read, way select, then update
//   and write-back, and the engine pops no new packet until it is done.
// Reset:
//   the table is swept invalid, one set per cycle, through every set;
//   packets queue in the classifier meanwhile. Config returns to
//   rate_limit 100 and window_ns 1e9.
// Stall:
//   a held result blocks the engine only; the two-entry queue and the
//   classifier stage keep accepting until they fill.
// ----------------------------------------------------------------------------
module syn_flood_rate_limiter #(
    parameter int TABLE_ENTRIES = snfrl_pkg::TABLE_ENTRIES_DEF,
    parameter int WAYS          = snfrl_pkg::WAYS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    snfrl_cfg_if.sink    cfg,
    snfrl_pkt_if.sink    pkt,
    snfrl_res_if.source  res
);

    localparam int NSETS = ((TABLE_ENTRIES / WAYS) > 0) ? (TABLE_ENTRIES / WAYS) : 1;
    localparam int SET_W = (NSETS > 1) ? $clog2(NSETS) : 1;
    localparam int QW    = 1 + SET_W + 32 + 64;

    logic [15:0]   rate_limit_reg;
    logic [39:0]   window_ns_reg;
    logic          q_push;
    logic [QW-1:0] q_push_data;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic [QW-1:0] q_pop_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_limit_reg <= snfrl_pkg::RATE_LIMIT_RST;
            window_ns_reg  <= snfrl_pkg::WINDOW_NS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                snfrl_pkg::CFG_RATE_LIMIT: rate_limit_reg <= cfg.data[15:0];
                snfrl_pkg::CFG_WINDOW_NS:  window_ns_reg  <= cfg.data;
                default:                   rate_limit_reg <= rate_limit_reg;
            endcase
        end
    end

    snfrl_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WAYS          (WAYS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pkt    (pkt),
        .q_push (q_push),
        .q_data (q_push_data),
        .q_full (q_full)
    );

    snfrl_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_pop_data)
    );

    snfrl_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WAYS          (WAYS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_pop_data),
        .q_pop      (q_pop),
        .rate_limit (rate_limit_reg),
        .window_ns  (window_ns_reg),
        .res        (res)
    );

endmodule

// ===== design/snfrl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snfrl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module snfrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/snfrl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snfrl_queue
// Two-entry queue between the classifier and the table engine.
// ----------------------------------------------------------------------------
module snfrl_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] pop_data
);

    localparam logic [1:0] DEPTH = 2'd2;

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;

    assign full      = (cnt_reg == DEPTH);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/snfrl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snfrl_front
// Packet classifier: decides whether a packet is tracked and finds its set.
// ----------------------------------------------------------------------------
module snfrl_front #(
    parameter int TABLE_ENTRIES = snfrl_pkg::TABLE_ENTRIES_DEF,
    parameter int WAYS          = snfrl_pkg::WAYS_DEF,
    localparam int NSETS = ((TABLE_ENTRIES / WAYS) > 0) ? (TABLE_ENTRIES / WAYS) : 1,
    localparam int SET_W = (NSETS > 1) ? $clog2(NSETS) : 1,
    localparam int QW    = 1 + SET_W + 32 + 64
) (
    input  logic          clk,
    input  logic          rst_n,
    snfrl_pkt_if.sink     pkt,
    output logic          q_push,
    output logic [QW-1:0] q_data,
    input  logic          q_full
);

    localparam bit IS_POW2 = ((NSETS & (NSETS - 1)) == 0);
    // reciprocal of the set count, exact for any 16-bit folded address
    localparam int     RCP_SH = 16 + SET_W;
    localparam longint RCP_M  = ((longint'(1) << RCP_SH) + longint'(NSETS) - 1)
                                / longint'(NSETS);

    logic              stage_valid_reg;
    logic              done_reg;
    logic              phase_reg;
    logic              tracked_reg;
    logic [31:0]       addr_reg;
    logic [63:0]       now_reg;
    logic [15:0]       fold_reg;
    logic [15:0]       quo_reg;
    logic [SET_W-1:0]  rem_reg;
    logic [33:0]       prod;
    logic [15:0]       quo_next;
    logic [15:0]       rem_calc;
    logic              accept;
    logic              tracked;
    logic [15:0]       fold;
    logic [SET_W-1:0]  set_direct;

    assign pkt.ready = !stage_valid_reg;
    assign accept    = pkt.valid && pkt.ready;

    assign tracked = (pkt.frame_length >= snfrl_pkg::MIN_FRAME)
                  && (pkt.ether_type == snfrl_pkg::ETHERTYPE_IPV4)
                  && (pkt.ip_protocol == snfrl_pkg::PROTO_TCP)
                  && pkt.syn_flag && !pkt.ack_flag;

    assign fold       = pkt.source_address[31:16] ^ pkt.source_address[15:0];
    assign set_direct = (NSETS == 1) ? '0 : fold[SET_W-1:0];

    // quotient first, then the remainder from it
    always_comb
    begin
        prod     = 34'(fold_reg) * 34'(RCP_M);
        quo_next = 16'(prod >> RCP_SH);
        rem_calc = fold_reg - 16'(32'(quo_reg) * 32'(NSETS));
    end

    assign q_push = stage_valid_reg && done_reg && !q_full;
    assign q_data = {tracked_reg, rem_reg, addr_reg, now_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            done_reg        <= 1'b0;
            phase_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
                done_reg        <= IS_POW2 || !tracked;
                phase_reg       <= 1'b0;
            end
            else if (q_push)
            begin
                stage_valid_reg <= 1'b0;
            end
            else if (stage_valid_reg && !done_reg)
            begin
                phase_reg <= 1'b1;
                if (phase_reg)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tracked_reg <= tracked;
            addr_reg    <= pkt.source_address;
            now_reg     <= pkt.now_ns;
            fold_reg    <= fold;
            rem_reg     <= IS_POW2 ? set_direct : '0;
        end
        else if (stage_valid_reg && !done_reg)
        begin
            if (!phase_reg)
            begin
                quo_reg <= quo_next;
            end
            else
            begin
                rem_reg <= rem_calc[SET_W-1:0];
            end
        end
    end

endmodule

// ===== design/snfrl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snfrl_back
// Table engine: set lookup, window and count update, recency, result register.
// ----------------------------------------------------------------------------
module snfrl_back #(
    parameter int TABLE_ENTRIES = snfrl_pkg::TABLE_ENTRIES_DEF,
    parameter int WAYS          = snfrl_pkg::WAYS_DEF,
    localparam int NSETS = ((TABLE_ENTRIES / WAYS) > 0) ? (TABLE_ENTRIES / WAYS) : 1,
    localparam int SET_W = (NSETS > 1) ? $clog2(NSETS) : 1,
    localparam int QW    = 1 + SET_W + 32 + 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  logic [QW-1:0] q_data,
    output logic          q_pop,
    input  logic [15:0]   rate_limit,
    input  logic [39:0]   window_ns,
    snfrl_res_if.source   res
);

    localparam int AGE_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_O  = 1;
    localparam int CNT_O  = AGE_O + AGE_W;
    localparam int TS_O   = CNT_O + 16;
    localparam int KEY_O  = TS_O + 64;
    localparam int WAY_W  = KEY_O + 32;
    localparam int ROW_W  = WAYS * WAY_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LOOK  = 4'b0100,
        S_EVAL  = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [SET_W-1:0]     clr_addr_reg;
    logic [SET_W-1:0]     set_reg;
    logic [31:0]          addr_reg;
    logic [63:0]          now_reg;
    logic                 hit_reg;
    logic                 free_reg;
    logic [WAY_IW-1:0]    way_reg;
    logic                 out_valid_reg;
    logic                 drop_reg;
    snfrl_pkg::outcome_t  outcome_reg;

    logic                 q_tracked;
    logic [SET_W-1:0]     q_set;
    logic                 out_free;

    logic                 ram_wr_en;
    logic [SET_W-1:0]     ram_wr_addr;
    logic [ROW_W-1:0]     ram_wr_data;
    logic                 ram_rd_en;
    logic [ROW_W-1:0]     row;

    logic                 v_vld [WAYS];
    logic [AGE_W-1:0]     v_age [WAYS];
    logic [15:0]          v_cnt [WAYS];
    logic [63:0]          v_ts  [WAYS];
    logic [31:0]          v_key [WAYS];

    logic                 hit;
    logic                 have_free;
    logic [WAY_IW-1:0]    hit_way;
    logic [WAY_IW-1:0]    free_way;
    logic [WAY_IW-1:0]    best_way;
    logic [WAY_IW-1:0]    sel_way;

    logic [63:0]          elapsed;
    logic                 restart;
    logic                 over;
    logic [AGE_W:0]       old_age;
    logic [ROW_W-1:0]     new_row;
    snfrl_pkg::outcome_t  eval_outcome;

    assign q_tracked = q_data[QW-1];
    assign q_set     = q_data[QW-2 -: SET_W];
    assign out_free  = !out_valid_reg || res.ready;
    assign q_pop     = (state_reg == S_IDLE) && q_valid && out_free;
    assign ram_rd_en = q_pop && q_tracked;

    snfrl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NSETS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (q_set),
        .rd_data (row)
    );

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            v_vld[w] = row[w*WAY_W];
            v_age[w] = row[w*WAY_W + AGE_O +: AGE_W];
            v_cnt[w] = row[w*WAY_W + CNT_O +: 16];
            v_ts[w]  = row[w*WAY_W + TS_O +: 64];
            v_key[w] = row[w*WAY_W + KEY_O +: 32];
        end
    end

    // hit, first free way and oldest way of the set
    always_comb
    begin
        hit       = 1'b0;
        hit_way   = '0;
        have_free = 1'b0;
        free_way  = '0;
        best_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (v_vld[w] && v_key[w] == addr_reg)
            begin
                hit     = 1'b1;
                hit_way = WAY_IW'(w);
            end
            if (!v_vld[w])
            begin
                have_free = 1'b1;
                free_way  = WAY_IW'(w);
            end
        end
        for (int w = 1; w < WAYS; w++)
        begin
            if (v_age[w] > v_age[best_way])
            begin
                best_way = WAY_IW'(w);
            end
        end
        sel_way = hit ? hit_way : (have_free ? free_way : best_way);
    end

    always_comb
    begin
        elapsed = now_reg - v_ts[way_reg];
        restart = elapsed > {24'd0, window_ns};
        over    = v_cnt[way_reg] >= rate_limit;
        if (!hit_reg && free_reg)
        begin
            old_age = (AGE_W + 1)'(WAYS);
        end
        else
        begin
            old_age = {1'b0, v_age[way_reg]};
        end

        new_row = row;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_IW'(w) != way_reg && v_vld[w] && {1'b0, v_age[w]} < old_age
                && v_age[w] < AGE_W'(WAYS - 1))
            begin
                new_row[w*WAY_W + AGE_O +: AGE_W] = v_age[w] + AGE_W'(1);
            end
        end
        new_row[int'(way_reg)*WAY_W + AGE_O +: AGE_W] = '0;

        if (!hit_reg)
        begin
            eval_outcome = snfrl_pkg::OUT_NEW;
            new_row[int'(way_reg)*WAY_W]               = 1'b1;
            new_row[int'(way_reg)*WAY_W + KEY_O +: 32] = addr_reg;
            new_row[int'(way_reg)*WAY_W + TS_O +: 64]  = now_reg;
            new_row[int'(way_reg)*WAY_W + CNT_O +: 16] = 16'd1;
        end
        else if (restart)
        begin
            eval_outcome = snfrl_pkg::OUT_RESTART;
            new_row[int'(way_reg)*WAY_W + TS_O +: 64]  = now_reg;
            new_row[int'(way_reg)*WAY_W + CNT_O +: 16] = 16'd1;
        end
        else if (over)
        begin
            eval_outcome = snfrl_pkg::OUT_OVER;
        end
        else
        begin
            eval_outcome = snfrl_pkg::OUT_COUNTED;
            new_row[int'(way_reg)*WAY_W + CNT_O +: 16] = v_cnt[way_reg] + 16'd1;
        end
    end

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = set_reg;
        ram_wr_data = new_row;
        if (state_reg == S_CLEAR)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '0;
        end
        else if (state_reg == S_EVAL)
        begin
            ram_wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == SET_W'(NSETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_pop && q_tracked)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + SET_W'(1);
            end
            if ((q_pop && !q_tracked) || state_reg == S_EVAL)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            set_reg  <= q_set;
            addr_reg <= q_data[95:64];
            now_reg  <= q_data[63:0];
        end
        if (state_reg == S_LOOK)
        begin
            hit_reg  <= hit;
            free_reg <= have_free;
            way_reg  <= sel_way;
        end
        if (q_pop && !q_tracked)
        begin
            drop_reg    <= 1'b0;
            outcome_reg <= snfrl_pkg::OUT_UNTRACKED;
        end
        else if (state_reg == S_EVAL)
        begin
            drop_reg    <= (eval_outcome == snfrl_pkg::OUT_OVER);
            outcome_reg <= eval_outcome;
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.drop    = drop_reg;
    assign res.outcome = outcome_reg;

`ifndef NO_ASSERTIONS
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !q_pop)
        else $error("queue popped during table clear");

    a_eval_after_look: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> ($past(state_reg) == S_LOOK))
        else $error("evaluation without a preceding lookup");

    a_untracked_result: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_tracked) |=> (out_valid_reg && outcome_reg == snfrl_pkg::OUT_UNTRACKED))
        else $error("untracked packet did not produce its result");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (!out_valid_reg || res.ready))
        else $error("result register overwritten before transfer");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the SYN flood rate limiter. Packets are sent through the
// packet channel and checked against a behavioral copy of the source table:
// classification, insert, window restart, counting, over-limit drops and
// LRU replacement. Registers are changed between phases while idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NSETS = snfrl_pkg::TABLE_ENTRIES_DEF / snfrl_pkg::WAYS_DEF;
    localparam int NWAYS = snfrl_pkg::WAYS_DEF;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                 drop;
        snfrl_pkg::outcome_t  outcome;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    snfrl_cfg_if cfg ();
    snfrl_pkt_if pkt ();
    snfrl_res_if res ();

    syn_flood_rate_limiter uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .pkt   (pkt),
        .res   (res)
    );

    always #6 clk = ~clk;

    // shadow of the source table
    logic [15:0] lim_q;
    logic [39:0] win_q;
    logic        tv_valid [NSETS][NWAYS];
    logic [31:0] tv_key   [NSETS][NWAYS];
    logic [63:0] tv_start [NSETS][NWAYS];
    logic [15:0] tv_count [NSETS][NWAYS];
    int          tv_age   [NSETS][NWAYS];

    verdict_t verdict_q[$];
    int  mismatches = 0;
    bit  steady = 0;        // no idling stretch
    bit  hold_off = 0;      // long receiver stall
    longint cycles = 0;

    function automatic void age_ways(int s, int way, int old_age);
        for (int w = 0; w < NWAYS; w++)
        begin
            if (w != way && tv_valid[s][w] && tv_age[s][w] < old_age &&
                tv_age[s][w] < NWAYS - 1)
                tv_age[s][w]++;
        end
        tv_age[s][way] = 0;
    endfunction

    function automatic verdict_t classify_packet(logic [15:0] flen, logic [15:0] et,
        logic [7:0] pr, logic syn, logic ack, logic [31:0] a, logic [63:0] now);
        verdict_t v;
        int s;
        int hw;
        int fw;
        int best;
        logic [63:0] el;
        v.drop = 1'b0;
        if (flen < snfrl_pkg::MIN_FRAME || et != snfrl_pkg::ETHERTYPE_IPV4 ||
            pr != snfrl_pkg::PROTO_TCP || syn != 1'b1 || ack != 1'b0)
        begin
            v.outcome = snfrl_pkg::OUT_UNTRACKED;
            return v;
        end
        s = int'((a[31:16] ^ a[15:0]) % NSETS);
        hw = -1;
        for (int w = 0; w < NWAYS; w++)
            if (hw < 0 && tv_valid[s][w] && tv_key[s][w] == a)
                hw = w;
        if (hw >= 0)
        begin
            el = now - tv_start[s][hw];
            if (el > {24'd0, win_q})
            begin
                tv_start[s][hw] = now;
                tv_count[s][hw] = 16'd1;
                v.outcome = snfrl_pkg::OUT_RESTART;
            end
            else if (tv_count[s][hw] >= lim_q)
            begin
                v.outcome = snfrl_pkg::OUT_OVER;
                v.drop = 1'b1;
            end
            else
            begin
                tv_count[s][hw]++;
                v.outcome = snfrl_pkg::OUT_COUNTED;
            end
            age_ways(s, hw, tv_age[s][hw]);
        end
        else
        begin
            fw = -1;
            for (int w = 0; w < NWAYS; w++)
                if (fw < 0 && !tv_valid[s][w])
                    fw = w;
            if (fw < 0)
            begin
                best = 0;
                for (int w = 1; w < NWAYS; w++)
                    if (tv_age[s][w] > tv_age[s][best])
                        best = w;
                fw = best;
                hw = tv_age[s][best];
            end
            else
                hw = NWAYS;
            tv_valid[s][fw] = 1'b1;
            tv_key[s][fw] = a;
            tv_start[s][fw] = now;
            tv_count[s][fw] = 16'd1;
            age_ways(s, fw, hw);
            v.outcome = snfrl_pkg::OUT_NEW;
        end
        return v;
    endfunction

    function automatic bit gap();
        return !steady && ($urandom_range(99) < 14);
    endfunction

    // valid stays high after the transfer; the next call or drain() updates it
    task automatic send_packet(logic [15:0] flen, logic [15:0] et, logic [7:0] pr,
        logic syn, logic ack, logic [31:0] a, logic [63:0] now);
        while (gap())
        begin
            pkt.valid <= 1'b0;
            @(posedge clk);
        end
        pkt.valid <= 1'b1;
        pkt.frame_length <= flen;
        pkt.ether_type <= et;
        pkt.ip_protocol <= pr;
        pkt.syn_flag <= syn;
        pkt.ack_flag <= ack;
        pkt.source_address <= a;
        pkt.now_ns <= now;
        @(posedge clk);
        while (!pkt.ready)
            @(posedge clk);
        verdict_q.push_back(classify_packet(flen, et, pr, syn, ack, a, now));
    endtask

    task automatic send_syn(logic [31:0] a, logic [63:0] now);
        send_packet(16'd60, snfrl_pkg::ETHERTYPE_IPV4, snfrl_pkg::PROTO_TCP, 1'b1, 1'b0,
            a, now);
    endtask

    task automatic drain();
        pkt.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(snfrl_pkg::cfg_index_t idx, logic [39:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (idx == snfrl_pkg::CFG_RATE_LIMIT)
            lim_q = value[15:0];
        else
            win_q = value;
        @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got.drop = res.drop;
            got.outcome = snfrl_pkg::outcome_t'(res.outcome);
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result drop=%0d outcome=%0d", got.drop, got.outcome);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (got.drop !== want.drop || got.outcome !== want.outcome)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected drop=%0d outcome=%0d, got drop=%0d outcome=%0d",
                            want.drop, want.outcome, got.drop, got.outcome);
                end
            end
        end
    end

    // receiver readiness
    always @(posedge clk)
    begin
        if (hold_off)
            res.ready <= 1'b0;
        else
            res.ready <= !gap();
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("syn_flood_rate_limiter regression: fail");
            $finish;
        end
    end

    task automatic test_classifier();
        send_packet(16'd53, snfrl_pkg::ETHERTYPE_IPV4, snfrl_pkg::PROTO_TCP, 1'b1, 1'b0,
            32'h0a000001, 64'd0);
        send_packet(16'd54, 16'h86dd, snfrl_pkg::PROTO_TCP, 1'b1, 1'b0, 32'h0a000001, 64'd0);
        send_packet(16'hffff, snfrl_pkg::ETHERTYPE_IPV4, 8'd17, 1'b1, 1'b0, 32'h0a000001,
            64'd0);
        send_packet(16'd0, 16'hffff, 8'hff, 1'b0, 1'b1, 32'hffffffff, '1);
        send_packet(16'd54, snfrl_pkg::ETHERTYPE_IPV4, snfrl_pkg::PROTO_TCP, 1'b1, 1'b1,
            32'h0a000001, 64'd0);
        send_packet(16'd54, snfrl_pkg::ETHERTYPE_IPV4, snfrl_pkg::PROTO_TCP, 1'b0, 1'b0,
            32'h0a000001, 64'd0);
        send_packet(16'd54, snfrl_pkg::ETHERTYPE_IPV4, snfrl_pkg::PROTO_TCP, 1'b1, 1'b0,
            32'h00000000, 64'd0);
        send_packet(16'hffff, snfrl_pkg::ETHERTYPE_IPV4, snfrl_pkg::PROTO_TCP, 1'b1, 1'b0,
            32'hffffffff, '1);
    endtask

    task automatic test_window();
        write_reg(snfrl_pkg::CFG_RATE_LIMIT, 40'd2);
        write_reg(snfrl_pkg::CFG_WINDOW_NS, 40'd100);
        send_syn(32'h01020304, 64'd1000);
        send_syn(32'h01020304, 64'd1050);
        send_syn(32'h01020304, 64'd1100);   // elapsed equal to window: over
        send_syn(32'h01020304, 64'd1101);   // restart
        // wrapping elapsed time
        send_syn(32'h05060708, 64'hffffffff_ffffffc0);
        send_syn(32'h05060708, 64'd10);
        drain();
        write_reg(snfrl_pkg::CFG_RATE_LIMIT, 40'd0);   // any hit in window drops
        send_syn(32'h01020304, 64'd1120);
        drain();
    endtask

    task automatic test_replacement();
        write_reg(snfrl_pkg::CFG_RATE_LIMIT, 40'd65535);
        write_reg(snfrl_pkg::CFG_WINDOW_NS, 40'hff_ffff_ffff);
        // same set: address halves XOR to the same value
        for (int i = 0; i < 6; i++)
            send_syn({16'(i + 1), 16'(i + 1) ^ 16'h0011}, 64'd5);
        send_syn({16'd3, 16'd3 ^ 16'h0011}, 64'd6);
        send_syn({16'd1, 16'd1 ^ 16'h0011}, 64'd6);
        drain();
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 20; i++)
                send_syn(32'h0a0a0000 | 32'(i % 3), 64'(i));
        join
        drain();
    endtask

    task automatic test_random(int n, logic [15:0] lim, logic [39:0] win);
        logic [31:0] a;
        logic [63:0] now;
        int k;
        write_reg(snfrl_pkg::CFG_RATE_LIMIT, {24'd0, lim});
        write_reg(snfrl_pkg::CFG_WINDOW_NS, win);
        now = {$urandom, $urandom};
        for (int i = 0; i < n; i++)
        begin
            steady = (i > n / 2) && (i < n / 2 + 60);
            now = now + 64'($urandom_range(win > 40'd64 ? 64 : 3));
            k = $urandom_range(99);
            // small address pool collides in sets and forces evictions
            a = {16'($urandom_range(9)), 16'($urandom_range(9))};
            if (k < 75)
                send_syn(a, now);
            else if (k < 80)
                send_syn($urandom, {$urandom, $urandom});
            else
                send_packet(16'($urandom),
                    ($urandom_range(1) ? snfrl_pkg::ETHERTYPE_IPV4 : 16'($urandom)),
                    ($urandom_range(1) ? snfrl_pkg::PROTO_TCP : 8'($urandom)),
                    1'($urandom), 1'($urandom), $urandom, {$urandom, $urandom});
        end
        steady = 0;
        drain();
    endtask

    initial
    begin
        lim_q = snfrl_pkg::RATE_LIMIT_RST;
        win_q = snfrl_pkg::WINDOW_NS_RST;
        foreach (tv_valid[s, w])
        begin
            tv_valid[s][w] = 1'b0;
            tv_age[s][w] = 0;
        end
        cfg.valid = 1'b0;
        cfg.index = snfrl_pkg::CFG_RATE_LIMIT;
        cfg.data = '0;
        pkt.valid = 1'b0;
        pkt.frame_length = '0;
        pkt.ether_type = '0;
        pkt.ip_protocol = '0;
        pkt.syn_flag = 1'b0;
        pkt.ack_flag = 1'b0;
        pkt.source_address = '0;
        pkt.now_ns = '0;
        res.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_classifier();
        drain();
        test_window();
        test_replacement();
        test_backpressure();
        test_random(300, 16'd3, 40'd200);
        test_random(250, 16'd1, 40'd1);
        test_random(200, 16'd65535, 40'hff_ffff_ffff);
        test_random(100, 16'd100, 40'd1000000000);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("syn_flood_rate_limiter regression: pass");
        else
            $display("syn_flood_rate_limiter regression: fail");
        $finish;
    end
endmodule
